>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
	`ASSERT_CLK(label, clk, rst_n, !(expr), msg)

`endif

>>> hdl/tkms_pkg.sv
`default_nettype none
package tkms_pkg;

	localparam int ScoreW       = 17;
	localparam int ImgW         = 16;
	localparam int KeepDepthDef = 6;
	localparam int IndexBitsDef = 16;
	localparam int RunQueueDepth = 2;

	localparam logic [ScoreW-1:0] ScoreOne    = 17'd65536;
	localparam logic [ScoreW-1:0] ThreshReset = 17'd58982;

endpackage
`default_nettype wire

>>> hdl/tkms_front.sv
`default_nettype none
`include "assert_macros.svh"
module tkms_front #(
	parameter int KEEP_DEPTH = tkms_pkg::KeepDepthDef,
	parameter int IDX_W      = tkms_pkg::IndexBitsDef,
	parameter int CNT_W      = $clog2(KEEP_DEPTH + 1),
	parameter int RUN_W      = IDX_W + CNT_W + KEEP_DEPTH * (tkms_pkg::ScoreW + IDX_W)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [tkms_pkg::ScoreW-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tkms_pkg::ImgW-1:0]   query_index,
	input  wire logic [tkms_pkg::ImgW-1:0]   candidate_index,
	input  wire logic [tkms_pkg::ScoreW-1:0] score,
	input  wire logic                        candidate_valid,
	input  wire logic                        group_last,
	input  wire logic                        run_full,
	output logic                             run_push,
	output logic [RUN_W-1:0]                 run_data
);

	logic [tkms_pkg::ScoreW-1:0] thresh_q;
	logic [CNT_W-1:0]            count_q;
	logic [KEEP_DEPTH-1:0][tkms_pkg::ScoreW-1:0] scores_q;
	logic [KEEP_DEPTH-1:0][IDX_W-1:0]            idx_q;

	logic [KEEP_DEPTH-1:0]                       ge;
	logic                                        hit;
	logic [CNT_W-1:0]                            ins_count;
	logic [KEEP_DEPTH-1:0][tkms_pkg::ScoreW-1:0] ins_scores;
	logic [KEEP_DEPTH-1:0][IDX_W-1:0]            ins_idx;
	logic [IDX_W-1:0]                            cand_idx;
	logic [IDX_W-1:0]                            qry_idx;
	logic                                        accept;

	assign cand_idx = candidate_index[IDX_W-1:0];
	assign qry_idx  = query_index[IDX_W-1:0];
	assign in_ready = !run_full;
	assign accept   = in_valid && in_ready;

	// Parallel compare against every held entry, then shift below the insert point.
	always_comb begin
		for (int i = 0; i < KEEP_DEPTH; i++) begin
			ge[i] = (count_q > CNT_W'(i)) && (scores_q[i] >= score);
		end
		hit = candidate_valid && (score >= thresh_q) && !ge[KEEP_DEPTH-1];
		ins_scores = scores_q;
		ins_idx    = idx_q;
		if (hit && !ge[0]) begin
			ins_scores[0] = score;
			ins_idx[0]    = cand_idx;
		end
		for (int i = 1; i < KEEP_DEPTH; i++) begin
			if (hit && !ge[i]) begin
				if (ge[i-1]) begin
					ins_scores[i] = score;
					ins_idx[i]    = cand_idx;
				end else begin
					ins_scores[i] = scores_q[i-1];
					ins_idx[i]    = idx_q[i-1];
				end
			end
		end
		if (hit && (count_q != CNT_W'(KEEP_DEPTH))) begin
			ins_count = count_q + 1'b1;
		end else begin
			ins_count = count_q;
		end
	end

	assign run_push = accept && group_last && (ins_count != '0);
	assign run_data = {qry_idx, ins_count, ins_scores, ins_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= tkms_pkg::ThreshReset;
			count_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				thresh_q <= cfg_wr_data;
			end
			if (accept) begin
				// drop the list once its run is handed to the queue
				count_q <= group_last ? '0 : ins_count;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scores_q <= ins_scores;
			idx_q    <= ins_idx;
		end
	end

	`ASSERT_NEVER(a_count_bound, clk, arst_n, count_q > CNT_W'(KEEP_DEPTH),
		"kept count exceeds list depth")

endmodule
`default_nettype wire

>>> hdl/tkms_run_queue.sv
`default_nettype none
`include "assert_macros.svh"
module tkms_run_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = tkms_pkg::RunQueueDepth
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] push_data,
	output logic                  full,
	input  wire logic             pop,
	output logic                  empty,
	output logic [WIDTH-1:0]      head_data
);

	localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CntW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PtrW-1:0]  wr_ptr_q;
	logic [PtrW-1:0]  rd_ptr_q;
	logic [CntW-1:0]  count_q;

	assign full      = (count_q == CntW'(DEPTH));
	assign empty     = (count_q == '0);
	assign head_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	`ASSERT_NEVER(a_no_overflow, clk, arst_n, push && full && !pop,
		"run pushed into a full queue")
	`ASSERT_NEVER(a_no_underflow, clk, arst_n, pop && empty,
		"run popped from an empty queue")

endmodule
`default_nettype wire

>>> hdl/tkms_back.sv
`default_nettype none
`include "assert_macros.svh"
module tkms_back #(
	parameter int KEEP_DEPTH = tkms_pkg::KeepDepthDef,
	parameter int IDX_W      = tkms_pkg::IndexBitsDef,
	parameter int CNT_W      = $clog2(KEEP_DEPTH + 1),
	parameter int RUN_W      = IDX_W + CNT_W + KEEP_DEPTH * (tkms_pkg::ScoreW + IDX_W)
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        run_empty,
	input  wire logic [RUN_W-1:0]            run_data,
	output logic                             run_pop,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             is_header,
	output logic [tkms_pkg::ImgW-1:0]        image_index,
	output logic [tkms_pkg::ScoreW-1:0]      out_score,
	output logic                             run_last
);

	localparam int SelW = (KEEP_DEPTH > 1) ? $clog2(KEEP_DEPTH) : 1;

	logic [IDX_W-1:0]                            h_query;
	logic [CNT_W-1:0]                            h_count;
	logic [KEEP_DEPTH-1:0][tkms_pkg::ScoreW-1:0] h_scores;
	logic [KEEP_DEPTH-1:0][IDX_W-1:0]            h_idx;

	logic [CNT_W-1:0] pos_q;
	logic [CNT_W-1:0] pos_m1;
	logic [SelW-1:0]  sel;
	logic             emit;
	logic             at_end;

	assign {h_query, h_count, h_scores, h_idx} = run_data;

	assign pos_m1  = pos_q - 1'b1;
	assign sel     = pos_m1[SelW-1:0];
	assign emit    = !run_empty && (!out_valid || out_ready);
	assign at_end  = (pos_q == h_count);
	assign run_pop = emit && at_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			pos_q     <= '0;
		end else begin
			if (emit) begin
				out_valid <= 1'b1;
				pos_q     <= at_end ? '0 : pos_q + 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Position zero is the header, then the entries best first.
	always_ff @(posedge clk) begin
		if (emit) begin
			if (pos_q == '0) begin
				is_header   <= 1'b1;
				image_index <= tkms_pkg::ImgW'(h_query);
				out_score   <= tkms_pkg::ScoreOne;
				run_last    <= 1'b0;
			end else begin
				is_header   <= 1'b0;
				image_index <= tkms_pkg::ImgW'(h_idx[sel]);
				out_score   <= h_scores[sel];
				run_last    <= at_end;
			end
		end
	end

	`ASSERT_NEVER(a_header_not_last, clk, arst_n, out_valid && is_header && run_last,
		"header flagged as final result of a run")
	`ASSERT_CLK(a_pop_after_entries, clk, arst_n, run_pop |-> (pos_q != '0),
		"run released before its entries were sent")

endmodule
`default_nettype wire

>>> hdl/thresholded_top_k_match_select_unit.sv
// Keeps the best KEEP_DEPTH candidates per query whose score reaches score_threshold,
// sorted by descending score with ties in arrival order. One input transaction is
// accepted every cycle while in_ready is high; the compare-and-shift insert into the
// kept list finishes in that cycle. On a group end with a non-empty list the run
// (query index plus kept entries) moves into a two-deep run queue and the list starts
// empty for the next group. The output side sends one result per cycle from the queue
// head while out_ready allows: a header (is_header set, score 1.0), then the entries
// best first, run_last on the final one, so a run of n entries gives n + 1 results.
// in_ready drops only while both queue slots hold runs still being sent. Results are
// registered at the output from the queue head. Write score_threshold only while idle.
`default_nettype none
module thresholded_top_k_match_select_unit #(
	parameter int KEEP_DEPTH = tkms_pkg::KeepDepthDef,
	parameter int INDEX_BITS = tkms_pkg::IndexBitsDef
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cfg_wr_en,
	input  wire logic [tkms_pkg::ScoreW-1:0] cfg_wr_data,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [tkms_pkg::ImgW-1:0]   query_index,
	input  wire logic [tkms_pkg::ImgW-1:0]   candidate_index,
	input  wire logic [tkms_pkg::ScoreW-1:0] score,
	input  wire logic                        candidate_valid,
	input  wire logic                        group_last,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             is_header,
	output logic [tkms_pkg::ImgW-1:0]        image_index,
	output logic [tkms_pkg::ScoreW-1:0]      out_score,
	output logic                             run_last
);

	localparam int IdxW = (INDEX_BITS < tkms_pkg::ImgW) ? INDEX_BITS : tkms_pkg::ImgW;
	localparam int CntW = $clog2(KEEP_DEPTH + 1);
	localparam int RunW = IdxW + CntW + KEEP_DEPTH * (tkms_pkg::ScoreW + IdxW);

	logic            run_push;
	logic            run_pop;
	logic            run_full;
	logic            run_empty;
	logic [RunW-1:0] run_in;
	logic [RunW-1:0] run_head;

	tkms_front #(
		.KEEP_DEPTH (KEEP_DEPTH),
		.IDX_W      (IdxW),
		.CNT_W      (CntW),
		.RUN_W      (RunW)
	) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.query_index     (query_index),
		.candidate_index (candidate_index),
		.score           (score),
		.candidate_valid (candidate_valid),
		.group_last      (group_last),
		.run_full        (run_full),
		.run_push        (run_push),
		.run_data        (run_in)
	);

	tkms_run_queue #(
		.WIDTH (RunW),
		.DEPTH (tkms_pkg::RunQueueDepth)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (run_push),
		.push_data (run_in),
		.full      (run_full),
		.pop       (run_pop),
		.empty     (run_empty),
		.head_data (run_head)
	);

	tkms_back #(
		.KEEP_DEPTH (KEEP_DEPTH),
		.IDX_W      (IdxW),
		.CNT_W      (CntW),
		.RUN_W      (RunW)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.run_empty   (run_empty),
		.run_data    (run_head),
		.run_pop     (run_pop),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.is_header   (is_header),
		.image_index (image_index),
		.out_score   (out_score),
		.run_last    (run_last)
	);

endmodule
`default_nettype wire

>>> tb/sv/tb_thresholded_top_k_match_select_unit.sv
`timescale 1ns / 100ps

module tb_thresholded_top_k_match_select_unit;

	localparam int                   ScoreW      = tkms_pkg::ScoreW;
	localparam int                   ImgW        = tkms_pkg::ImgW;
	localparam int                   KeepDepth   = tkms_pkg::KeepDepthDef;
	localparam logic [ScoreW-1:0]    ScoreOne    = tkms_pkg::ScoreOne;
	localparam logic [ScoreW-1:0]    ThreshReset = tkms_pkg::ThreshReset;
	localparam logic [ScoreW-1:0]    ScoreMax    = '1;
	localparam int CycleLimit = 200000;
	localparam int DrainCycles = 20;

	typedef struct packed {
		logic              is_hdr;
		logic [ImgW-1:0]   img;
		logic [ScoreW-1:0] sc;
		logic              last;
	} match_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_wr_en = 1'b0;
	logic [ScoreW-1:0] cfg_wr_data = '0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [ImgW-1:0]   query_index = '0;
	logic [ImgW-1:0]   candidate_index = '0;
	logic [ScoreW-1:0] score = '0;
	logic              candidate_valid = 1'b0;
	logic              group_last = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              is_header;
	logic [ImgW-1:0]   image_index;
	logic [ScoreW-1:0] out_score;
	logic              run_last;

	// ranking model state
	logic [ScoreW-1:0] thresh_model = ThreshReset;
	logic [ScoreW-1:0] ranked_scores [KeepDepth];
	logic [ImgW-1:0]   ranked_ids [KeepDepth];
	int                ranked_count = 0;
	match_result_t     pending_matches [$];

	int errors = 0;
	int items_sent = 0;
	int results_checked = 0;
	int runs_seen = 0;
	int full_runs = 0;
	int thresh_settings = 0;
	int cycle_count = 0;

	// sender / receiver pacing
	int gap_max = 3;
	int burst_left = 0;
	int rx_mode = 0;
	int stall_left = 0;

	thresholded_top_k_match_select_unit dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.query_index     (query_index),
		.candidate_index (candidate_index),
		.score           (score),
		.candidate_valid (candidate_valid),
		.group_last      (group_last),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.is_header       (is_header),
		.image_index     (image_index),
		.out_score       (out_score),
		.run_last        (run_last)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CycleLimit) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				pending_matches.size());
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string msg);
		$display("%0t: %s", $time, msg);
		errors++;
	endtask

	// Insert one transaction into the ranking and emit the run on a non-empty group end.
	task automatic rank_item(input logic [ImgW-1:0] q, input logic [ImgW-1:0] c,
		input logic [ScoreW-1:0] s, input logic v, input logic l);
		int pos;
		int k;
		match_result_t r;
		if (v && s >= thresh_model) begin
			pos = 0;
			while (pos < ranked_count && ranked_scores[pos] >= s)
				pos++;
			if (pos < KeepDepth) begin
				k = (ranked_count < KeepDepth) ? ranked_count : KeepDepth - 1;
				while (k > pos) begin
					ranked_scores[k] = ranked_scores[k-1];
					ranked_ids[k] = ranked_ids[k-1];
					k--;
				end
				ranked_scores[pos] = s;
				ranked_ids[pos] = c;
				if (ranked_count < KeepDepth)
					ranked_count++;
			end
		end
		if (l && ranked_count != 0) begin
			r = '{is_hdr: 1'b1, img: q, sc: ScoreOne, last: 1'b0};
			pending_matches = {pending_matches, r};
			for (k = 0; k < ranked_count; k++) begin
				r = '{is_hdr: 1'b0, img: ranked_ids[k], sc: ranked_scores[k],
					last: (k == ranked_count - 1)};
				pending_matches = {pending_matches, r};
			end
			runs_seen++;
			if (ranked_count == KeepDepth)
				full_runs++;
			ranked_count = 0;
		end
	endtask

	task automatic check_match();
		match_result_t e;
		if (pending_matches.size() == 0) begin
			report_mismatch($sformatf("unexpected result hdr=%0b idx=%0h score=%0h last=%0b",
				is_header, image_index, out_score, run_last));
		end else begin
			e = pending_matches.pop_front();
			results_checked++;
			if (is_header !== e.is_hdr)
				report_mismatch($sformatf("is_header got %0b expected %0b", is_header, e.is_hdr));
			if (image_index !== e.img)
				report_mismatch($sformatf("image_index got %0h expected %0h", image_index, e.img));
			if (out_score !== e.sc)
				report_mismatch($sformatf("out_score got %0h expected %0h", out_score, e.sc));
			if (run_last !== e.last)
				report_mismatch($sformatf("run_last got %0b expected %0b", run_last, e.last));
		end
	endtask

	// sample every transaction at the edge where it completes
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_wr_en)
				thresh_model = cfg_wr_data;
			if (in_valid && in_ready) begin
				rank_item(query_index, candidate_index, score, candidate_valid, group_last);
				items_sent++;
			end
			if (out_valid && out_ready)
				check_match();
		end
	end

	// receiver stall patterns
	always @(posedge clk) begin
		case (rx_mode)
			0: begin
				out_ready <= 1'b1;
			end
			1: begin
				out_ready <= ($urandom_range(0, 3) != 0);
			end
			default: begin
				if (stall_left > 0) begin
					stall_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 4) == 0) begin
					stall_left = $urandom_range(0, 6);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// Hold valid until the transaction is taken; valid stays high for the next item unless a random gap follows.
	task automatic send_item(input logic [ImgW-1:0] q, input logic [ImgW-1:0] c,
		input logic [ScoreW-1:0] s, input logic v, input logic l);
		int gap;
		in_valid <= 1'b1;
		query_index <= q;
		candidate_index <= c;
		score <= s;
		candidate_valid <= v;
		group_last <= l;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(0, gap_max);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		// let the last accepted transaction reach the model first
		@(posedge clk);
		while (pending_matches.size() != 0 || out_valid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_threshold(input logic [ScoreW-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		thresh_settings++;
	endtask

	function automatic logic [ScoreW-1:0] pick_score();
		int s;
		case ($urandom_range(0, 4))
			0: s = $urandom_range(0, ScoreMax);
			1, 2: s = int'(thresh_model) + $urandom_range(0, 4095) - 2048;
			3: s = int'(thresh_model) + 16 * $urandom_range(0, 3);
			default: s = $urandom_range(0, ScoreOne);
		endcase
		if (s < 0)
			s = 0;
		if (s > ScoreMax)
			s = ScoreMax;
		return s[ScoreW-1:0];
	endfunction

	// reset threshold: one below and exactly at it, noise, empty group end
	task automatic test_reset_threshold();
		send_item(16'h0000, 16'h0001, ThreshReset - 1'b1, 1'b1, 1'b0);
		send_item(16'h0000, 16'h0002, ThreshReset, 1'b1, 1'b0);
		send_item(16'h0000, 16'h0003, ScoreMax, 1'b0, 1'b0);
		send_item(16'h0000, 16'h0004, ScoreMax, 1'b0, 1'b1);
		send_item(16'hFFFF, 16'h0005, 17'd0, 1'b0, 1'b1);
		wait_idle();
	endtask

	// overflow the list: ties, zero score, beyond 1.0, displacement, drop
	task automatic test_list_overflow();
		set_threshold('0);
		send_item(16'hFFFF, 16'h0010, 17'd100, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0011, 17'd200, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0012, 17'd200, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0000, 17'd0, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0013, ScoreMax, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0014, ScoreOne, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0015, 17'd50, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'h0016, 17'd50, 1'b1, 1'b0);
		send_item(16'hFFFF, 16'hFFFF, 17'd150, 1'b1, 1'b1);
		send_item(16'h1234, 16'h0017, 17'd0, 1'b1, 1'b1);
		wait_idle();
	endtask

	// threshold at the top of the register range and at exactly 1.0
	task automatic test_threshold_extremes();
		set_threshold(ScoreMax);
		send_item(16'h0042, 16'h0020, ScoreMax - 1'b1, 1'b1, 1'b0);
		send_item(16'h0042, 16'h0021, ScoreMax, 1'b1, 1'b1);
		wait_idle();
		set_threshold(ScoreOne);
		send_item(16'h0043, 16'h0022, ScoreOne - 1'b1, 1'b1, 1'b0);
		send_item(16'h0043, 16'h0023, ScoreOne, 1'b1, 1'b0);
		send_item(16'h0043, 16'h0024, 17'd0, 1'b0, 1'b1);
		wait_idle();
	endtask

	// random groups with scores around the threshold, a little noise
	task automatic test_random_groups(input int n_items, input logic [ScoreW-1:0] thr);
		int target;
		int len;
		int i;
		logic [ImgW-1:0] q;
		set_threshold(thr);
		target = items_sent + n_items;
		while (items_sent < target) begin
			q = ImgW'($urandom_range(0, 16'hFFFF));
			len = $urandom_range(1, 10);
			if ($urandom_range(0, 9) == 0) begin
				// broken group: end marker with nothing kept
				send_item(q, ImgW'($urandom_range(0, 16'hFFFF)),
					ScoreW'($urandom_range(0, ScoreMax)), 1'b0, 1'b1);
			end else begin
				for (i = 0; i < len; i++) begin
					if (i != len - 1 && $urandom_range(0, 9) == 0)
						send_item(q, ImgW'($urandom_range(0, 16'hFFFF)),
							ScoreW'($urandom_range(0, ScoreMax)), 1'b0, 1'b0);
					else
						send_item(q, ImgW'($urandom_range(0, 16'hFFFF)), pick_score(),
							(i != len - 1) || ($urandom_range(0, 3) != 0), i == len - 1);
				end
			end
		end
		wait_idle();
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rx_mode = 0;
		gap_max = 2;
		test_reset_threshold();
		rx_mode = 2;
		test_list_overflow();
		rx_mode = 1;
		test_threshold_extremes();

		rx_mode = 0;
		gap_max = 0;
		test_random_groups(80, ScoreW'($urandom_range(0, ScoreOne)));
		rx_mode = 1;
		gap_max = 4;
		test_random_groups(75, '0);
		rx_mode = 2;
		gap_max = 3;
		test_random_groups(75, ScoreOne);
		rx_mode = 1;
		gap_max = 0;
		test_random_groups(80, ScoreW'($urandom_range(0, ScoreOne)));
		rx_mode = 2;
		gap_max = 5;
		test_random_groups(75, ThreshReset);

		in_valid <= 1'b0;
		while (pending_matches.size() != 0)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (pending_matches.size() != 0)
			report_mismatch($sformatf("%0d results never arrived", pending_matches.size()));

		$display("Sent %0d transactions under %0d threshold settings; checked %0d results",
			items_sent, thresh_settings, results_checked);
		$display("in %0d runs, %0d of them with a full list; %0d mismatches.",
			runs_seen, full_runs, errors);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
